// File: rtl/core/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler to quaternion block
// Number formats, CORDIC arctangent table and the rotator state records.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_TABLE     = 32;
    localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_TABLE) ? MAX_TABLE : CORDIC_STAGES;
    localparam int STAGE_W       = $clog2(MAX_TABLE);

    // x, y in Q30 with headroom; z is a 32-bit binary angle (2^31 = pi)
    localparam int XY_W   = 33;
    localparam int Z_W    = 32;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = 16;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

    localparam int NUM_AXES = 3;
    localparam int AX_ROLL  = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_YAW   = 2;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    typedef t_rot [NUM_AXES-1:0] t_rot3;

    function automatic logic signed [Z_W-1:0] atan_angle(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 32'sh20000000;
            5'd1:    a = 32'sh12E4051E;
            5'd2:    a = 32'sh09FB385B;
            5'd3:    a = 32'sh051111D4;
            5'd4:    a = 32'sh028B0D43;
            5'd5:    a = 32'sh0145D7E1;
            5'd6:    a = 32'sh00A2F61E;
            5'd7:    a = 32'sh00517C55;
            5'd8:    a = 32'sh0028BE53;
            5'd9:    a = 32'sh00145F2F;
            5'd10:   a = 32'sh000A2F98;
            5'd11:   a = 32'sh000517CC;
            5'd12:   a = 32'sh00028BE6;
            5'd13:   a = 32'sh000145F3;
            5'd14:   a = 32'sh0000A2FA;
            5'd15:   a = 32'sh0000517D;
            5'd16:   a = 32'sh000028BE;
            5'd17:   a = 32'sh0000145F;
            5'd18:   a = 32'sh00000A30;
            5'd19:   a = 32'sh00000518;
            5'd20:   a = 32'sh0000028C;
            5'd21:   a = 32'sh00000146;
            5'd22:   a = 32'sh000000A3;
            5'd23:   a = 32'sh00000051;
            5'd24:   a = 32'sh00000029;
            5'd25:   a = 32'sh00000014;
            5'd26:   a = 32'sh0000000A;
            5'd27:   a = 32'sh00000005;
            5'd28:   a = 32'sh00000003;
            5'd29:   a = 32'sh00000001;
            5'd30:   a = 32'sh00000001;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one CORDIC rotation step for roll, pitch and yaw
// Registered micro-rotation of three vectors by +/- atan(2^-stage).
// ----------------------------------------------------------------------------
module e2q_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [e2q_pkg::STAGE_W-1:0]   i_stage,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  e2q_pkg::t_rot3                i_rot,
    output logic                          o_valid,
    input  logic                          i_stall,
    output e2q_pkg::t_rot3                o_rot
);

    logic                           r_valid;
    e2q_pkg::t_rot3                 r_rot;
    e2q_pkg::t_rot3                 n_rot;
    logic signed [e2q_pkg::Z_W-1:0] atan_val;

    assign atan_val = e2q_pkg::atan_angle(i_stage);
    assign o_stall  = r_valid && i_stall;

    always_comb begin
        logic signed [e2q_pkg::XY_W-1:0] dx;
        logic signed [e2q_pkg::XY_W-1:0] dy;
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
            dx = i_rot[a].y >>> i_stage;
            dy = i_rot[a].x >>> i_stage;
            if (!i_rot[a].z[e2q_pkg::Z_W-1]) begin
                n_rot[a].x = i_rot[a].x - dx;
                n_rot[a].y = i_rot[a].y + dy;
                n_rot[a].z = i_rot[a].z - atan_val;
            end else begin
                n_rot[a].x = i_rot[a].x + dx;
                n_rot[a].y = i_rot[a].y - dy;
                n_rot[a].z = i_rot[a].z + atan_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;

endmodule

// File: rtl/core/e2q_quat_mult.sv
// ----------------------------------------------------------------------------
// e2q_quat_mult: quaternion assembly from sines and cosines
// Pair products, triple products, then sum, round and saturate to Q1.15.
// ----------------------------------------------------------------------------
module e2q_quat_mult (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  e2q_pkg::t_rot3                     i_rot,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [e2q_pkg::Q_W-1:0]     o_quat_w,
    output logic signed [e2q_pkg::Q_W-1:0]     o_quat_x,
    output logic signed [e2q_pkg::Q_W-1:0]     o_quat_y,
    output logic signed [e2q_pkg::Q_W-1:0]     o_quat_z
);

    localparam int TW = e2q_pkg::TRIG_W;
    localparam int PW = e2q_pkg::PROD_W;
    localparam int SW = e2q_pkg::SUM_W;
    localparam int QW = e2q_pkg::Q_W;

    function automatic logic signed [QW-1:0] sat_q15(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        logic signed [QW-1:0] q;
        r = (s + (SW'(1) <<< 44)) >>> 45;
        if (r > SW'(32767)) begin
            q = 16'sh7FFF;
        end else if (r < -SW'(32768)) begin
            q = 16'sh8000;
        end else begin
            q = r[QW-1:0];
        end
        return q;
    endfunction

    function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
        logic signed [PW-1:0] p;
        p = (a * b + (PW'(1) <<< 29)) >>> 30;
        return p[TW-1:0];
    endfunction

    logic signed [TW-1:0] cr, sr, cp, sp, cy, sy;

    logic                 r_v1, r_v2, r_v3;
    logic                 s1_stall, s2_stall, s3_stall;
    logic signed [TW-1:0] r_cr, r_sr, r_cpcy, r_spsy, r_spcy, r_cpsy;
    logic signed [PW-1:0] r_t [8];
    logic signed [QW-1:0] r_w, r_x, r_y, r_z;

    assign cr = i_rot[e2q_pkg::AX_ROLL].x[TW-1:0];
    assign sr = i_rot[e2q_pkg::AX_ROLL].y[TW-1:0];
    assign cp = i_rot[e2q_pkg::AX_PITCH].x[TW-1:0];
    assign sp = i_rot[e2q_pkg::AX_PITCH].y[TW-1:0];
    assign cy = i_rot[e2q_pkg::AX_YAW].x[TW-1:0];
    assign sy = i_rot[e2q_pkg::AX_YAW].y[TW-1:0];

    assign s3_stall = r_v3 && i_stall;
    assign s2_stall = r_v2 && s3_stall;
    assign s1_stall = r_v1 && s2_stall;
    assign o_stall  = s1_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!s1_stall) begin
                r_v1 <= i_valid;
            end
            if (!s2_stall) begin
                r_v2 <= r_v1;
            end
            if (!s3_stall) begin
                r_v3 <= r_v2;
            end
        end
    end

    // pair products
    always_ff @(posedge i_clk) begin
        if (!s1_stall && i_valid) begin
            r_cr   <= cr;
            r_sr   <= sr;
            r_cpcy <= mul_q30(cp, cy);
            r_spsy <= mul_q30(sp, sy);
            r_spcy <= mul_q30(sp, cy);
            r_cpsy <= mul_q30(cp, sy);
        end
    end

    // triple products
    always_ff @(posedge i_clk) begin
        if (!s2_stall && r_v1) begin
            r_t[0] <= r_cr * r_cpcy;
            r_t[1] <= r_sr * r_spsy;
            r_t[2] <= r_sr * r_cpcy;
            r_t[3] <= r_cr * r_spsy;
            r_t[4] <= r_cr * r_spcy;
            r_t[5] <= r_sr * r_cpsy;
            r_t[6] <= r_cr * r_cpsy;
            r_t[7] <= r_sr * r_spcy;
        end
    end

    // sum, round, saturate
    always_ff @(posedge i_clk) begin
        if (!s3_stall && r_v2) begin
            r_w <= sat_q15(SW'(r_t[0]) + SW'(r_t[1]));
            r_x <= sat_q15(SW'(r_t[2]) - SW'(r_t[3]));
            r_y <= sat_q15(SW'(r_t[4]) + SW'(r_t[5]));
            r_z <= sat_q15(SW'(r_t[6]) - SW'(r_t[7]));
        end
    end

    assign o_valid  = r_v3;
    assign o_quat_w = r_w;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;

endmodule

// File: rtl/core/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: ZYX Euler angles to attitude quaternion
// Pipelined CORDIC sine/cosine of the half angles and quaternion products.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with roll, pitch and yaw binary angles
//   (full signed range = -pi .. pi). A request is taken on a rising edge
//   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with w, x, y, z in signed Q1.15,
//   saturated to 32767 at +1.0.
//   Stages: CORDIC_STAGES registered CORDIC cells (16 stages), then the
//   registered pair products, triple products and the rounded sums.
//   Throughput: one request per cycle while o_stall is low; every cell
//   and every product stage is registered and advances independently.
//   Receiver stall: the output register holds its result; stages behind it
//   keep filling until a full stage reaches the input, then o_stall rises.
//   Reset (synchronous, active low) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] i_roll_angle,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] i_pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] i_yaw_angle,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [e2q_pkg::Q_W-1:0]       o_quat_w,
    output logic signed [e2q_pkg::Q_W-1:0]       o_quat_x,
    output logic signed [e2q_pkg::Q_W-1:0]       o_quat_y,
    output logic signed [e2q_pkg::Q_W-1:0]       o_quat_z
);

    localparam int NS = e2q_pkg::NUM_STAGES;
    localparam int ZW = e2q_pkg::Z_W;

    e2q_pkg::t_rot3 rot_in;
    e2q_pkg::t_rot3 cell_rot   [NS+1];
    logic           cell_valid [NS+1];
    logic           cell_stall [NS+1];

    function automatic logic signed [ZW-1:0] half_angle(
        input logic signed [e2q_pkg::ANGLE_WIDTH-1:0] ang);
        logic signed [ZW-1:0] v;
        v = ZW'(ang) <<< (ZW - e2q_pkg::ANGLE_WIDTH);
        return v >>> 1;
    endfunction

    always_comb begin
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
            rot_in[a].x = e2q_pkg::GAIN_Q30;
            rot_in[a].y = '0;
        end
        rot_in[e2q_pkg::AX_ROLL].z  = half_angle(i_roll_angle);
        rot_in[e2q_pkg::AX_PITCH].z = half_angle(i_pitch_angle);
        rot_in[e2q_pkg::AX_YAW].z   = half_angle(i_yaw_angle);
    end

    assign cell_rot[0]   = rot_in;
    assign cell_valid[0] = i_valid;
    assign o_stall       = cell_stall[0];

    for (genvar g = 0; g < NS; g++) begin : g_cell
        e2q_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (e2q_pkg::STAGE_W'(g)),
            .i_valid (cell_valid[g]),
            .o_stall (cell_stall[g]),
            .i_rot   (cell_rot[g]),
            .o_valid (cell_valid[g+1]),
            .i_stall (cell_stall[g+1]),
            .o_rot   (cell_rot[g+1])
        );
    end

    e2q_quat_mult u_quat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cell_valid[NS]),
        .o_stall  (cell_stall[NS]),
        .i_rot    (cell_rot[NS]),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_to_quaternion
// Drives roll/pitch/yaw angle triples through the valid/stall input channel,
// predicts each quaternion with a bit-exact CORDIC model of its own and
// checks every output field in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

    typedef logic signed [e2q_pkg::ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [e2q_pkg::Q_W-1:0]         t_qval;

    typedef struct packed {
        t_angle roll;
        t_angle pitch;
        t_angle yaw;
        bit     drain;  // hold this request until all results are back
    } t_euler_req;

    typedef struct packed {
        t_qval w;
        t_qval x;
        t_qval y;
        t_qval z;
    } t_quat;

    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint ROUND_Q30       = 64'sd1 << 29;
    localparam longint ROUND_Q15       = 64'sd1 << 44;
    localparam int     LONG_HOLD       = 150;
    localparam int     DRAIN_CYCLES    = e2q_pkg::CORDIC_STAGES + 8;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   i_stall       = 1'b0;
    t_angle i_roll_angle  = '0;
    t_angle i_pitch_angle = '0;
    t_angle i_yaw_angle   = '0;
    logic   o_stall;
    logic   o_valid;
    t_qval  o_quat_w;
    t_qval  o_quat_x;
    t_qval  o_quat_y;
    t_qval  o_quat_z;

    t_euler_req pending_angles[$];
    t_quat      expected_quats[$];

    int n_triples_sent  = 0;
    int n_quats_checked = 0;
    int n_errors        = 0;
    int n_backpressure  = 0;
    int n_hold_cycles   = 0;

    euler_to_quaternion i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_roll_angle  (i_roll_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_quat_w      (o_quat_w),
        .o_quat_x      (o_quat_x),
        .o_quat_y      (o_quat_y),
        .o_quat_z      (o_quat_z)
    );

    // ------------------------------------------------------------------
    // Quaternion predictor
    // ------------------------------------------------------------------
    function automatic longint arctan_step(int k);
        case (k)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            29: return 64'h00000001;
            30: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // cosine and sine of half the angle, Q30
    function automatic void half_sincos(input t_angle ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = (longint'(ang) <<< (32 - e2q_pkg::ANGLE_WIDTH)) >>> 1;
        for (int k = 0; k < e2q_pkg::NUM_STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(k);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(k);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + ROUND_Q30) >>> 30;
    endfunction

    function automatic t_qval q15_sat(longint sum_q60);
        longint r;
        r = (sum_q60 + ROUND_Q15) >>> 45;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return t_qval'(r);
    endfunction

    function automatic t_quat quat_from_euler(t_angle roll, t_angle pitch, t_angle yaw);
        longint cr, sr, cp, sp, cy, sy;
        longint cpcy, spsy, spcy, cpsy;
        t_quat  q;
        half_sincos(roll, cr, sr);
        half_sincos(pitch, cp, sp);
        half_sincos(yaw, cy, sy);
        cpcy = q30_mul(cp, cy);
        spsy = q30_mul(sp, sy);
        spcy = q30_mul(sp, cy);
        cpsy = q30_mul(cp, sy);
        q.w = q15_sat(cr * cpcy + sr * spsy);
        q.x = q15_sat(sr * cpcy - cr * spsy);
        q.y = q15_sat(cr * spcy + sr * cpsy);
        q.z = q15_sat(cr * cpsy - sr * spcy);
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int idle_len(bit quiet);
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_request(int roll, int pitch, int yaw, bit drain);
        t_euler_req r;
        r.roll  = t_angle'(roll);
        r.pitch = t_angle'(pitch);
        r.yaw   = t_angle'(yaw);
        r.drain = drain;
        pending_angles.push_back(r);
    endfunction

    function automatic int near_landmark();
        int base;
        case ($urandom_range(0, 4))
            0:       base = -32768;
            1:       base = -16384;
            2:       base = 0;
            3:       base = 16384;
            default: base = 32767;
        endcase
        return base + $urandom_range(0, 16) - 8;
    endfunction

    function automatic int rand_angle();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return $urandom_range(0, 65535);
        if (mode < 8)
            return near_landmark();
        return $urandom_range(0, 512) - 256;
    endfunction

    task automatic report(string msg);
        if (n_errors < 32)
            $display("[%0t] %s", $time, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    int         send_gap = 0;
    bit         req_fire;
    t_euler_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            req_fire = i_valid && !o_stall;
            if (i_valid && o_stall)
                n_backpressure++;
            if (req_fire) begin
                expected_quats.push_back(quat_from_euler(i_roll_angle, i_pitch_angle,
                                                         i_yaw_angle));
                n_triples_sent++;
            end
            if (req_fire || !i_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_angles.size() != 0 &&
                             !(pending_angles[0].drain && expected_quats.size() != 0)) begin
                    next_req = pending_angles.pop_front();
                    i_valid       <= 1'b1;
                    i_roll_angle  <= next_req.roll;
                    i_pitch_angle <= next_req.pitch;
                    i_yaw_angle   <= next_req.yaw;
                    send_gap = idle_len(((n_triples_sent / 128) % 4) == 1);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------
    int    hold_left  = 0;
    int    stall_left = 0;
    int    go_left    = 0;
    t_quat want_quat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_quats.size() == 0) begin
                    report($sformatf("unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                                     o_quat_w, o_quat_x, o_quat_y, o_quat_z));
                end else begin
                    want_quat = expected_quats.pop_front();
                    if (o_quat_w !== want_quat.w)
                        report($sformatf("quat_w mismatch on result %0d: got %0d, expected %0d",
                                         n_quats_checked, o_quat_w, want_quat.w));
                    if (o_quat_x !== want_quat.x)
                        report($sformatf("quat_x mismatch on result %0d: got %0d, expected %0d",
                                         n_quats_checked, o_quat_x, want_quat.x));
                    if (o_quat_y !== want_quat.y)
                        report($sformatf("quat_y mismatch on result %0d: got %0d, expected %0d",
                                         n_quats_checked, o_quat_y, want_quat.y));
                    if (o_quat_z !== want_quat.z)
                        report($sformatf("quat_z mismatch on result %0d: got %0d, expected %0d",
                                         n_quats_checked, o_quat_z, want_quat.z));
                end
                n_quats_checked++;
                // long receiver hold-off so the pipeline fills and stalls its input
                if ((n_quats_checked % 1000) == 300)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                n_hold_cycles++;
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (go_left != 0) begin
                    go_left--;
                end else begin
                    stall_left = idle_len(((n_quats_checked / 128) % 4) == 2);
                    go_left    = $urandom_range(0, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("timeout: %0d requests sent, %0d results checked",
                 n_triples_sent, n_quats_checked);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        add_request(0, 0, 0, 1'b0);
        add_request(-32768, 0, 0, 1'b0);
        add_request(0, -32768, 0, 1'b0);
        add_request(0, 0, -32768, 1'b0);
        add_request(-32768, -32768, -32768, 1'b0);
        add_request(32767, 32767, 32767, 1'b0);
        add_request(32767, 0, 0, 1'b0);
        add_request(0, 32767, 0, 1'b0);
        add_request(0, 0, 32767, 1'b0);
        add_request(16384, 0, 0, 1'b0);
        add_request(0, 16384, 0, 1'b0);
        add_request(0, 0, 16384, 1'b0);
        add_request(-16384, -16384, -16384, 1'b0);
        add_request(16384, 16384, 16384, 1'b0);
        add_request(1, -1, 1, 1'b0);
        add_request(-1, 1, -1, 1'b0);
        add_request(21845, -21846, 21845, 1'b0);
        add_request(-21846, 21845, -21846, 1'b0);
        add_request(8192, -8192, 24576, 1'b0);
        add_request(-32768, 32767, 0, 1'b0);
        add_request(32767, -32768, 16384, 1'b0);
        add_request(0, -16384, 32767, 1'b0);
        add_request(4096, 12288, -20480, 1'b0);
        for (int i = 0; i < 2000; i++)
            add_request(rand_angle(), rand_angle(), rand_angle(), i == 0 || i == 1000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_angles.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_quats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d angle triples and %0d quaternions with random idling",
                 n_triples_sent, n_quats_checked);
        $display("input held off %0d cycles, long receiver hold-off %0d cycles, %0d errors",
                 n_backpressure, n_hold_cycles, n_errors);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
